// ===== hw/rtl/mqttpp_pkg.sv =====
// Package for the MQTT PUBLISH packet parser: item types, result kinds and
// parser phase codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mqttpp_pkg;

   localparam int unsigned LEN_W = 28;

   localparam logic [1:0] KIND_TOPIC   = 2'd0;
   localparam logic [1:0] KIND_INFO    = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_TLEN_HI = 3'd2;
   localparam logic [2:0] PH_TLEN_LO = 3'd3;
   localparam logic [2:0] PH_TOPIC   = 3'd4;
   localparam logic [2:0] PH_ID_HI   = 3'd5;
   localparam logic [2:0] PH_ID_LO   = 3'd6;
   localparam logic [2:0] PH_PAYLOAD = 3'd7;

   localparam logic [1:0] LEN_CNT_MAX = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       pkt_start;
   } mqttpp_req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data_byte;
      logic [1:0]       qos_level;
      logic [15:0]      message_id;
      logic [15:0]      topic_length;
      logic [LEN_W-1:0] payload_length;
      logic             last;
      logic             error;
   } mqttpp_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mqttpp_req_if.sv =====
// Request channel interface: one packet byte per transfer.
// Depends on mqttpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mqttpp_req_if import mqttpp_pkg::*; ();
   logic           valid;
   logic           ready;
   mqttpp_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mqttpp_rsp_if.sv =====
// Response channel interface: one parser result per transfer.
// Depends on mqttpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mqttpp_rsp_if import mqttpp_pkg::*; ();
   logic           valid;
   logic           ready;
   mqttpp_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mqttpp_core.sv =====
// Parser state and per-byte decode: updates the packet state for one byte
// when enabled and presents the result that byte causes. Depends on mqttpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mqttpp_core import mqttpp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step_en,
   input  wire mqttpp_req_type item,
   output logic                has_rsp,
   output mqttpp_rsp_type      rsp
);

   logic [2:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] rem_len_ff, rem_len_in;
   logic [1:0]       len_cnt_ff, len_cnt_in;
   logic [15:0]      topic_len_ff, topic_len_in;
   logic [15:0]      topic_cnt_ff, topic_cnt_in;
   logic [1:0]       qos_ff, qos_in;
   logic [15:0]      msg_id_ff, msg_id_in;
   logic [LEN_W-1:0] pay_cnt_ff, pay_cnt_in;

   logic [7:0]       b;
   logic [LEN_W-1:0] len_part;
   logic [15:0]      tlen_full;
   logic [17:0]      need;
   logic             too_short;
   logic [LEN_W-1:0] pay_len;
   logic [15:0]      topic_cnt_inc;
   logic [15:0]      msg_id_full;
   logic [LEN_W-1:0] pay_cnt_dec;

   assign b             = item.in_byte;
   assign tlen_full     = {topic_len_ff[15:8], b};
   assign need          = 18'(tlen_full) + 18'd2 + ((qos_ff != 2'd0) ? 18'd2 : 18'd0);
   assign too_short     = rem_len_ff < LEN_W'(need);
   assign pay_len       = rem_len_ff - LEN_W'(need);
   assign topic_cnt_inc = topic_cnt_ff + 16'd1;
   assign msg_id_full   = {msg_id_ff[15:8], b};
   assign pay_cnt_dec   = pay_cnt_ff - LEN_W'(1);

   always_comb begin
      case (len_cnt_ff)
         2'd0: len_part = {21'd0, b[6:0]};
         2'd1: len_part = {14'd0, b[6:0], 7'd0};
         2'd2: len_part = {7'd0, b[6:0], 14'd0};
         default: len_part = {b[6:0], 21'd0};
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      rem_len_in   = rem_len_ff;
      len_cnt_in   = len_cnt_ff;
      topic_len_in = topic_len_ff;
      topic_cnt_in = topic_cnt_ff;
      qos_in       = qos_ff;
      msg_id_in    = msg_id_ff;
      pay_cnt_in   = pay_cnt_ff;
      has_rsp      = 1'b0;
      rsp          = '0;

      if (item.pkt_start) begin
         qos_in       = b[2:1];
         rem_len_in   = '0;
         len_cnt_in   = '0;
         topic_len_in = '0;
         topic_cnt_in = '0;
         msg_id_in    = '0;
         pay_cnt_in   = '0;
         phase_in     = PH_LEN;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               rem_len_in = rem_len_ff | len_part;
               if (b[7] && (len_cnt_ff < LEN_CNT_MAX)) begin
                  len_cnt_in = len_cnt_ff + 2'd1;
               end else begin
                  phase_in = PH_TLEN_HI;
               end
            end
            PH_TLEN_HI: begin
               topic_len_in = {b, 8'd0};
               phase_in     = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
               topic_len_in = tlen_full;
               if (too_short) begin
                  has_rsp            = 1'b1;
                  rsp.kind           = KIND_INFO;
                  rsp.qos_level      = qos_ff;
                  rsp.topic_length   = tlen_full;
                  rsp.last           = 1'b1;
                  rsp.error          = 1'b1;
                  phase_in           = PH_IDLE;
               end else begin
                  pay_cnt_in   = pay_len;
                  topic_cnt_in = '0;
                  if (qos_ff == 2'd0) begin
                     has_rsp            = 1'b1;
                     rsp.kind           = KIND_INFO;
                     rsp.topic_length   = tlen_full;
                     rsp.payload_length = pay_len;
                     rsp.last           = (tlen_full == 16'd0) && (pay_len == '0);
                     if (tlen_full != 16'd0) begin
                        phase_in = PH_TOPIC;
                     end else if (pay_len != '0) begin
                        phase_in = PH_PAYLOAD;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     phase_in = (tlen_full != 16'd0) ? PH_TOPIC : PH_ID_HI;
                  end
               end
            end
            PH_TOPIC: begin
               topic_cnt_in  = topic_cnt_inc;
               has_rsp       = 1'b1;
               rsp.kind      = KIND_TOPIC;
               rsp.data_byte = b;
               if (topic_cnt_inc >= topic_len_ff) begin
                  if (qos_ff != 2'd0) begin
                     phase_in = PH_ID_HI;
                  end else if (pay_cnt_ff == '0) begin
                     rsp.last = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_ID_HI: begin
               msg_id_in = {b, 8'd0};
               phase_in  = PH_ID_LO;
            end
            PH_ID_LO: begin
               msg_id_in          = msg_id_full;
               has_rsp            = 1'b1;
               rsp.kind           = KIND_INFO;
               rsp.qos_level      = qos_ff;
               rsp.message_id     = msg_id_full;
               rsp.topic_length   = topic_len_ff;
               rsp.payload_length = pay_cnt_ff;
               rsp.last           = (pay_cnt_ff == '0);
               phase_in           = (pay_cnt_ff != '0) ? PH_PAYLOAD : PH_IDLE;
            end
            PH_PAYLOAD: begin
               if (pay_cnt_ff == '0) begin
                  phase_in = PH_IDLE;
               end else begin
                  pay_cnt_in    = pay_cnt_dec;
                  has_rsp       = 1'b1;
                  rsp.kind      = KIND_PAYLOAD;
                  rsp.data_byte = b;
                  rsp.last      = (pay_cnt_dec == '0);
                  if (pay_cnt_dec == '0) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rem_len_ff   <= '0;
         len_cnt_ff   <= '0;
         topic_len_ff <= '0;
         topic_cnt_ff <= '0;
         qos_ff       <= '0;
         msg_id_ff    <= '0;
         pay_cnt_ff   <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         rem_len_ff   <= rem_len_in;
         len_cnt_ff   <= len_cnt_in;
         topic_len_ff <= topic_len_in;
         topic_cnt_ff <= topic_cnt_in;
         qos_ff       <= qos_in;
         msg_id_ff    <= msg_id_in;
         pay_cnt_ff   <= pay_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mqtt_publish_packet_parser.sv =====
// Top level of the MQTT PUBLISH packet parser: input register, decode core
// and result register. Depends on mqttpp_pkg, mqttpp_req_if, mqttpp_rsp_if, mqttpp_core.
//
//   channel   direction   carries
//   req_ch    in          in_byte, pkt_start (one packet byte)
//   rsp_ch    out         kind, data_byte, qos_level, message_id, topic_length,
//                         payload_length, last, error
//
// One byte is taken per cycle while no result-causing byte is held behind a waiting result;
// each result passes the input register, the decode core's state update and the result register, which form
// the path; the result register limits the rate only while a result waits unclaimed.
// Bytes that cause no result pass the decode stage even while a result waits.
// Reset is synchronous and clears the parser to idle; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_publish_packet_parser import mqttpp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   mqttpp_req_if.sink     req_ch,
   mqttpp_rsp_if.source   rsp_ch
);

   logic           in_valid_ff, in_valid_in;
   mqttpp_req_type in_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   mqttpp_rsp_type rsp_data_ff;

   logic           core_has_rsp;
   mqttpp_rsp_type core_rsp;
   logic           out_free;
   logic           stage_go;
   logic           req_xfer;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign stage_go = in_valid_ff && (!core_has_rsp || out_free);
   assign req_ch.ready = !in_valid_ff || stage_go;
   assign req_xfer = req_ch.valid && req_ch.ready;

   mqttpp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (stage_go),
      .item    (in_item_ff),
      .has_rsp (core_has_rsp),
      .rsp     (core_rsp)
   );

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (stage_go && core_has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_ch.data;
      end
      if (stage_go && core_has_rsp) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // A held byte that cannot advance is still held on the next cycle.
   a_hold_stalled_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !stage_go |=> in_valid_ff)
      else $error("stalled input byte was dropped");

   // An error result is a final info result with no payload.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.error |->
         rsp_data_ff.last && (rsp_data_ff.kind == KIND_INFO) &&
         (rsp_data_ff.payload_length == '0))
      else $error("malformed error result");

   // Only defined result kinds are presented.
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.kind == KIND_TOPIC) ||
         (rsp_data_ff.kind == KIND_INFO) || (rsp_data_ff.kind == KIND_PAYLOAD))
      else $error("undefined result kind");

   // A result produced by the decode stage never overwrites a waiting one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      stage_go && core_has_rsp |-> out_free)
      else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== dv/tb_mqtt_publish_packet_parser.sv =====
// Self-checking testbench for mqtt_publish_packet_parser: random PUBLISH packets with bursty
// input and stalled output, checked against an in-bench parser model.
// Depends on mqttpp_pkg, mqttpp_req_if, mqttpp_rsp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_mqtt_publish_packet_parser;
   import mqttpp_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1800;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           drv_valid = 1'b0;
   mqttpp_req_type drv_data = '0;
   logic           rsp_ready = 1'b0;
   logic           req_taken = 1'b0;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned item_count = 0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 0;
   int unsigned pattern_age = 0;
   logic [7:0]  stall_pattern = 8'hFF;

   mqttpp_req_type pending_bytes[$];
   mqttpp_rsp_type expected_results[$];

   logic [2:0]       parse_phase = PH_IDLE;
   logic [LEN_W-1:0] rem_len = '0;
   logic [1:0]       len_cnt = '0;
   logic [15:0]      topic_len = '0;
   logic [15:0]      topic_cnt = '0;
   logic [1:0]       qos_q = '0;
   logic [15:0]      msg_id = '0;
   logic [LEN_W-1:0] payload_left = '0;

   mqttpp_req_if req_ch ();
   mqttpp_rsp_if rsp_ch ();

   assign req_ch.valid = drv_valid;
   assign req_ch.data  = drv_data;
   assign rsp_ch.ready = rsp_ready;

   mqtt_publish_packet_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit parse_byte(input mqttpp_req_type it, output mqttpp_rsp_type res);
      logic [7:0]  b;
      int unsigned need;
      bit          produced;
      b = it.in_byte;
      res = '0;
      produced = 1'b0;
      if (it.pkt_start) begin
         qos_q = b[2:1];
         rem_len = '0;
         len_cnt = '0;
         topic_len = '0;
         topic_cnt = '0;
         msg_id = '0;
         payload_left = '0;
         parse_phase = PH_LEN;
      end else begin
         case (parse_phase)
            PH_LEN: begin
               rem_len = rem_len | (LEN_W'(b[6:0]) << (7 * len_cnt));
               if (b[7] && len_cnt < LEN_CNT_MAX) len_cnt = len_cnt + 2'd1;
               else parse_phase = PH_TLEN_HI;
            end
            PH_TLEN_HI: begin
               topic_len = {b, 8'h00};
               parse_phase = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
               topic_len[7:0] = b;
               need = 2 + int'(topic_len) + ((qos_q != 2'd0) ? 2 : 0);
               if (rem_len < need) begin
                  res.kind = KIND_INFO;
                  res.qos_level = qos_q;
                  res.topic_length = topic_len;
                  res.last = 1'b1;
                  res.error = 1'b1;
                  parse_phase = PH_IDLE;
                  produced = 1'b1;
               end else begin
                  payload_left = LEN_W'(rem_len - need);
                  topic_cnt = '0;
                  if (qos_q == 2'd0) begin
                     res.kind = KIND_INFO;
                     res.topic_length = topic_len;
                     res.payload_length = payload_left;
                     res.last = (topic_len == 16'd0 && payload_left == '0);
                     produced = 1'b1;
                     if (topic_len != 16'd0) parse_phase = PH_TOPIC;
                     else if (payload_left != '0) parse_phase = PH_PAYLOAD;
                     else parse_phase = PH_IDLE;
                  end else begin
                     parse_phase = (topic_len != 16'd0) ? PH_TOPIC : PH_ID_HI;
                  end
               end
            end
            PH_TOPIC: begin
               topic_cnt = topic_cnt + 16'd1;
               if (topic_cnt >= topic_len) begin
                  if (qos_q != 2'd0) begin
                     parse_phase = PH_ID_HI;
                  end else if (payload_left == '0) begin
                     res.last = 1'b1;
                     parse_phase = PH_IDLE;
                  end else begin
                     parse_phase = PH_PAYLOAD;
                  end
               end
               res.kind = KIND_TOPIC;
               res.data_byte = b;
               produced = 1'b1;
            end
            PH_ID_HI: begin
               msg_id = {b, 8'h00};
               parse_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
               msg_id[7:0] = b;
               res.kind = KIND_INFO;
               res.qos_level = qos_q;
               res.message_id = msg_id;
               res.topic_length = topic_len;
               res.payload_length = payload_left;
               res.last = (payload_left == '0);
               parse_phase = (payload_left != '0) ? PH_PAYLOAD : PH_IDLE;
               produced = 1'b1;
            end
            PH_PAYLOAD: begin
               if (payload_left == '0) begin
                  parse_phase = PH_IDLE;
               end else begin
                  payload_left = payload_left - 1'b1;
                  res.kind = KIND_PAYLOAD;
                  res.data_byte = b;
                  res.last = (payload_left == '0);
                  if (res.last) parse_phase = PH_IDLE;
                  produced = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      return produced;
   endfunction

   function automatic void check_field(input string name, input logic [LEN_W-1:0] want,
                                       input logic [LEN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      mqttpp_rsp_type want;
      mqttpp_rsp_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d data %0h last %0b",
                        $time, got.kind, got.data_byte, got.last);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", LEN_W'(want.kind), LEN_W'(got.kind));
               check_field("data_byte", LEN_W'(want.data_byte), LEN_W'(got.data_byte));
               check_field("qos_level", LEN_W'(want.qos_level), LEN_W'(got.qos_level));
               check_field("message_id", LEN_W'(want.message_id), LEN_W'(got.message_id));
               check_field("topic_length", LEN_W'(want.topic_length),
                           LEN_W'(got.topic_length));
               check_field("payload_length", want.payload_length, got.payload_length);
               check_field("last", LEN_W'(want.last), LEN_W'(got.last));
               check_field("error", LEN_W'(want.error), LEN_W'(got.error));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (parse_byte(req_ch.data, want)) expected_results.push_back(want);
         end
      end
      req_taken <= req_ch.valid && req_ch.ready;
      cycle_count <= cycle_count + 1;
   end

   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            drv_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            drv_data <= pending_bytes.pop_front();
            drv_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (pattern_age == 0) begin
         pattern_age = $urandom_range(20, 80);
         if ($urandom_range(0, 3) == 0) stall_pattern = 8'hFF;
         else stall_pattern = 8'($urandom) | 8'h01;
      end
      pattern_age--;
      rsp_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
   end

   task automatic push_byte(input logic [7:0] b, input logic start);
      mqttpp_req_type it;
      it.in_byte = b;
      it.pkt_start = start;
      pending_bytes.push_back(it);
   endtask

   task automatic add_publish(input logic [1:0] qos, input logic [LEN_W-1:0] rem,
                              input logic [15:0] tlen, input bit stretch,
                              input int unsigned max_body);
      logic [7:0]       hdr;
      logic [7:0]       b;
      logic [LEN_W-1:0] tmp;
      int unsigned      nlen;
      int unsigned      body;
      int unsigned      i;
      hdr = 8'($urandom);
      hdr[2:1] = qos;
      push_byte(hdr, 1'b1);
      nlen = 1;
      tmp = rem >> 7;
      while (tmp != '0) begin
         nlen++;
         tmp = tmp >> 7;
      end
      if (stretch) nlen = $urandom_range(4, nlen);
      for (i = 0; i < nlen; i++) begin
         b = 8'((rem >> (7 * i)) & 'h7F);
         if (i < nlen - 1) b[7] = 1'b1;
         else if (i == 3) b[7] = 1'($urandom_range(0, 1));
         push_byte(b, 1'b0);
      end
      push_byte(tlen[15:8], 1'b0);
      push_byte(tlen[7:0], 1'b0);
      body = (rem >= 2) ? int'(rem) - 2 : 0;
      if (body > max_body) body = max_body;
      for (i = 0; i < body; i++) push_byte(8'($urandom), 1'b0);
      item_count += 3 + nlen + body;
   endtask

   initial begin : stimulus
      int unsigned sel;
      int unsigned need;
      int unsigned plen;
      int unsigned n;
      logic [1:0]  qos;
      logic [15:0] tlen;

      push_byte(8'hFF, 1'b0);
      add_publish(2'd0, LEN_W'(2), 16'd0, 1'b0, 32'hFFFF_FFFF);
      push_byte(8'h36, 1'b1);
      push_byte(8'h04, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h34, 1'b1);
      push_byte(8'h03, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h30, 1'b1);
      repeat (4) push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      item_count = 24;

      while (item_count < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         qos = 2'($urandom);
         tlen = 16'($urandom_range(0, 6));
         plen = $urandom_range(0, 10);
         need = 2 + int'(tlen) + ((qos != 2'd0) ? 2 : 0);
         if (sel < 65) begin
            add_publish(qos, LEN_W'(need + plen), tlen, $urandom_range(0, 4) == 0,
                        32'hFFFF_FFFF);
         end else if (sel < 77) begin
            if ($urandom_range(0, 3) == 0) tlen = 16'($urandom);
            need = 2 + int'(tlen) + ((qos != 2'd0) ? 2 : 0);
            add_publish(qos, LEN_W'($urandom_range(0, need - 1)), tlen,
                        $urandom_range(0, 4) == 0, $urandom_range(0, 3));
         end else if (sel < 90) begin
            if ($urandom_range(0, 3) == 0) tlen = 16'($urandom);
            else tlen = 16'($urandom_range(0, 12));
            add_publish(qos, LEN_W'($urandom), tlen, $urandom_range(0, 4) == 0,
                        $urandom_range(0, 16));
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom), $urandom_range(0, 5) == 0);
            item_count += n;
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while ((pending_bytes.size() != 0 || drv_valid || expected_results.size() != 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
         $display("RESULT: ERROR");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (error_count == 0 && expected_results.size() == 0) $display("RESULT: OK");
         else $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
